[sv/aerm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Active entry ring manager package
// Shared widths, codes, payload structs and controller interface structs.
// ----------------------------------------------------------------------------
package aerm_pkg;

  localparam int ENTRY_W     = 6;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int ENTRIES_DEF = 64;

  localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ROTATE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALREADY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ENTRY_W-1:0]  entry;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  head_entry;
    logic [ENTRY_W-1:0]  tail_entry;
    logic                is_empty;
  } rsp_t;

  typedef struct packed {
    logic                load;
    logic                rd_en;
    logic                rd_head;
    logic                enq_link;
    logic                enq_self;
    logic                rm_last;
    logic                rm_link;
    logic                rot_step;
    logic                out_load;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                entry_ok;
    logic                entry_active;
    logic                empty;
    logic                single;
    logic                out_busy;
  } stat_t;

endpackage
`default_nettype wire

[sv/aerm_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Active entry ring manager datapath
// Link memories, active marks, head and tail registers and the result register.
// ----------------------------------------------------------------------------
module aerm_datapath #(
  parameter int ENTRIES = aerm_pkg::ENTRIES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire aerm_pkg::req_t req,
  input  wire aerm_pkg::cmd_t cmd,
  output aerm_pkg::stat_t     stat,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output aerm_pkg::rsp_t      rsp
);
  import aerm_pkg::*;

  localparam int SLOTS = (ENTRIES < (1 << ENTRY_W)) ? ENTRIES : (1 << ENTRY_W);
  localparam int AW    = $clog2(SLOTS);

  logic [ACTION_W-1:0] act_q;
  logic [ENTRY_W-1:0]  ent_q;
  logic [ENTRY_W-1:0]  head;
  logic [ENTRY_W-1:0]  tail;
  logic                ring_empty;
  logic [SLOTS-1:0]    active;
  logic [ENTRY_W-1:0]  next_mem [SLOTS];
  logic [ENTRY_W-1:0]  prev_mem [SLOTS];
  logic [ENTRY_W-1:0]  rd_next;
  logic [ENTRY_W-1:0]  rd_prev;

  logic [AW-1:0]       ent_addr;
  logic [AW-1:0]       rd_addr;
  logic                nw_en;
  logic [AW-1:0]       nw_addr;
  logic [ENTRY_W-1:0]  nw_data;
  logic                pw_en;
  logic [AW-1:0]       pw_addr;
  logic [ENTRY_W-1:0]  pw_data;

  assign ent_addr = AW'(ent_q);
  assign rd_addr  = cmd.rd_head ? AW'(head) : ent_addr;

  always_comb begin
    stat.action       = act_q;
    stat.entry_ok     = {1'b0, ent_q} < (ENTRY_W + 1)'(SLOTS);
    stat.entry_active = stat.entry_ok && active[ent_addr];
    stat.empty        = ring_empty;
    stat.single       = (head == tail);
    stat.out_busy     = rsp_valid && rsp_stall;
  end

  always_comb begin
    nw_en   = 1'b0;
    nw_addr = ent_addr;
    nw_data = ent_q;
    pw_en   = 1'b0;
    pw_addr = ent_addr;
    pw_data = ent_q;
    if (cmd.enq_link) begin
      nw_en   = 1'b1;
      nw_addr = AW'(tail);
      pw_en   = 1'b1;
      pw_addr = AW'(head);
    end else if (cmd.enq_self) begin
      nw_en   = 1'b1;
      nw_data = ring_empty ? ent_q : head;
      pw_en   = 1'b1;
      pw_data = ring_empty ? ent_q : tail;
    end else if (cmd.rm_link) begin
      nw_en   = 1'b1;
      nw_addr = AW'(rd_prev);
      nw_data = rd_next;
      pw_en   = 1'b1;
      pw_addr = AW'(rd_next);
      pw_data = rd_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (nw_en) begin
      next_mem[nw_addr] <= nw_data;
    end
    if (pw_en) begin
      prev_mem[pw_addr] <= pw_data;
    end
    if (cmd.rd_en) begin
      rd_next <= next_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= req.action;
      ent_q <= req.entry;
    end
    if (cmd.out_load) begin
      rsp.status     <= cmd.status;
      rsp.head_entry <= ring_empty ? '0 : head;
      rsp.tail_entry <= ring_empty ? '0 : tail;
      rsp.is_empty   <= ring_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      ring_empty <= 1'b1;
      active     <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.enq_self) begin
        tail             <= ent_q;
        active[ent_addr] <= 1'b1;
        ring_empty       <= 1'b0;
        if (ring_empty) begin
          head <= ent_q;
        end
      end
      if (cmd.rm_last) begin
        head             <= '0;
        tail             <= '0;
        ring_empty       <= 1'b1;
        active[ent_addr] <= 1'b0;
      end
      if (cmd.rm_link) begin
        active[ent_addr] <= 1'b0;
        if (rd_next == head) begin
          tail <= rd_prev;
        end else if (rd_prev == tail) begin
          head <= rd_next;
        end
      end
      if (cmd.rot_step) begin
        head <= rd_next;
        tail <= head;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[sv/aerm_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Active entry ring manager controller
// Sequences the link reads and writes of each action and picks the status.
// ----------------------------------------------------------------------------
module aerm_controller (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire aerm_pkg::stat_t stat,
  output aerm_pkg::cmd_t       cmd
);
  import aerm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ENQ2,
    S_RM_W,
    S_ROT_W,
    S_RESP
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [STATUS_W-1:0] status_q;
  logic [STATUS_W-1:0] status_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.status  = status_q;
    state_next  = state;
    status_next = status_q;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        status_next = ST_DONE;
        state_next  = S_RESP;
        unique case (stat.action)
          ACT_ENQUEUE: begin
            if (!stat.entry_ok) begin
              status_next = ST_NOT_ACTIVE;
            end else if (stat.entry_active) begin
              status_next = ST_ALREADY;
            end else if (stat.empty) begin
              cmd.enq_self = 1'b1;
            end else begin
              cmd.enq_link = 1'b1;
              state_next   = S_ENQ2;
            end
          end
          ACT_REMOVE: begin
            if (!stat.entry_active) begin
              status_next = ST_NOT_ACTIVE;
            end else if (stat.single) begin
              cmd.rm_last = 1'b1;
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_RM_W;
            end
          end
          ACT_ROTATE: begin
            if (stat.empty) begin
              status_next = ST_EMPTY;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_head = 1'b1;
              state_next  = S_ROT_W;
            end
          end
          default: begin
            status_next = ST_DONE;
          end
        endcase
      end
      S_ENQ2: begin
        cmd.enq_self = 1'b1;
        state_next   = S_RESP;
      end
      S_RM_W: begin
        cmd.rm_link = 1'b1;
        state_next  = S_RESP;
      end
      S_ROT_W: begin
        cmd.rot_step = 1'b1;
        state_next   = S_RESP;
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      status_q <= ST_DONE;
    end else begin
      state    <= state_next;
      status_q <= status_next;
    end
  end

endmodule
`default_nettype wire

[sv/active_entry_ring_manager_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Active entry ring manager
// Round-robin ring of active entries kept as a circular doubly linked list.
// ----------------------------------------------------------------------------
// Each transfer runs from acceptance through decode to a registered result;
// enqueue into a non-empty ring, remove from a longer ring and rotate pass
// through an extra state that writes the entry's own links or uses the links
// read in decode. The result waits while the output is stalled, and a new
// transfer is accepted the cycle after the result is registered.
// Reset clears the active marks, head, tail and sets the ring empty; the link
// memories are not cleared and need no clearing pass.
module active_entry_ring_manager_top #(
  parameter int ENTRIES = aerm_pkg::ENTRIES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire aerm_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output aerm_pkg::rsp_t      rsp
);
  import aerm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  aerm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  aerm_datapath #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

[bench/active_entry_ring_manager_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Active entry ring manager testbench
// Drives enqueue, remove, rotate and unused requests into the ring manager.
// A behavioral copy of the linked ring predicts each result, and the
// predictions are checked in order against the results that the block sends.
// Both channels idle at random in some phases and run back to back in others.
// ----------------------------------------------------------------------------
module active_entry_ring_manager_top_tb;
  import aerm_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int REPORT_LIMIT   = 10;
  localparam int RANDOM_ITEMS   = 1530;
  localparam int MODE_SPAN      = 200;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  bit [ENTRY_W-1:0]   link_next [ENTRIES_DEF];
  bit [ENTRY_W-1:0]   link_prev [ENTRIES_DEF];
  bit                 member [ENTRIES_DEF];
  logic [ENTRY_W-1:0] ring_head     = '0;
  logic [ENTRY_W-1:0] ring_tail     = '0;
  bit                 ring_is_empty = 1'b1;
  int                 ring_size     = 0;
  int                 peak_size     = 0;

  rsp_t expected_rsp_q[$];
  int   status_seen [4];
  int   items_sent      = 0;
  int   directed_items  = 0;
  int   results_checked = 0;
  int   error_count     = 0;
  int   quiet_cycles    = 0;
  int   stall_left      = 0;
  bit   req_idle_on     = 1'b0;
  bit   rsp_idle_on     = 1'b0;

  active_entry_ring_manager_top #(
    .ENTRIES(ENTRIES_DEF)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic rsp_t ring_apply(input req_t item);
    rsp_t               res;
    logic [ENTRY_W-1:0] e;
    logic [ENTRY_W-1:0] nx;
    logic [ENTRY_W-1:0] pv;
    e = item.entry;
    res = '0;
    res.status = ST_DONE;
    case (item.action)
      ACT_ENQUEUE: begin
        if (int'(e) >= ENTRIES_DEF) begin
          res.status = ST_NOT_ACTIVE;
        end else if (member[e]) begin
          res.status = ST_ALREADY;
        end else begin
          if (ring_is_empty) begin
            ring_head = e;
            ring_tail = e;
            link_next[e] = e;
            link_prev[e] = e;
            ring_is_empty = 1'b0;
          end else begin
            link_next[ring_tail] = e;
            link_prev[ring_head] = e;
            link_prev[e] = ring_tail;
            link_next[e] = ring_head;
            ring_tail = e;
          end
          member[e] = 1'b1;
          ring_size++;
        end
      end
      ACT_REMOVE: begin
        if (int'(e) >= ENTRIES_DEF || !member[e]) begin
          res.status = ST_NOT_ACTIVE;
        end else begin
          member[e] = 1'b0;
          ring_size--;
          if (ring_head == ring_tail) begin
            ring_head = '0;
            ring_tail = '0;
            ring_is_empty = 1'b1;
          end else begin
            nx = link_next[e];
            pv = link_prev[e];
            if (nx == ring_head) begin
              ring_tail = pv;
            end else if (pv == ring_tail) begin
              ring_head = nx;
            end
            link_next[pv] = nx;
            link_prev[nx] = pv;
          end
        end
      end
      ACT_ROTATE: begin
        if (ring_is_empty) begin
          res.status = ST_EMPTY;
        end else begin
          ring_head = link_next[ring_head];
          ring_tail = link_next[ring_tail];
        end
      end
      default: begin
      end
    endcase
    res.head_entry = ring_is_empty ? '0 : ring_head;
    res.tail_entry = ring_is_empty ? '0 : ring_tail;
    res.is_empty   = ring_is_empty;
    return res;
  endfunction

  function automatic int gap_length();
    if ($urandom_range(0, 99) < 80) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [ENTRY_W-1:0] find_entry(input bit want_member);
    int                 start;
    int                 k;
    bit                 found;
    logic [ENTRY_W-1:0] idx;
    logic [ENTRY_W-1:0] pick;
    start = $urandom_range(0, ENTRIES_DEF - 1);
    pick = ENTRY_W'(start);
    found = 1'b0;
    for (k = 0; k < ENTRIES_DEF; k++) begin
      idx = ENTRY_W'((start + k) % ENTRIES_DEF);
      if (!found && member[idx] == want_member) begin
        pick = idx;
        found = 1'b1;
      end
    end
    return pick;
  endfunction

  task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $write("%0t: %s: expected status %0d head %0d tail %0d empty %0d, ",
             $realtime, what, want.status, want.head_entry, want.tail_entry, want.is_empty);
      $display("got status %0d head %0d tail %0d empty %0d",
               got.status, got.head_entry, got.tail_entry, got.is_empty);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_op(input logic [ACTION_W-1:0] act, input logic [ENTRY_W-1:0] ent);
    req_t item;
    int   gap;
    item.action = act;
    item.entry  = ent;
    gap = 0;
    if (req_idle_on && $urandom_range(0, 99) >= 50) begin
      gap = gap_length();
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_stall <= 1'b1;
    end else if (rsp_idle_on && $urandom_range(0, 99) < 30) begin
      stall_left <= gap_length() - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    bit   moved;
    if (!rst) begin
      moved = 1'b0;
      if (rsp_valid && !rsp_stall) begin
        moved = 1'b1;
        results_checked++;
        if (expected_rsp_q.size() == 0) begin
          note_mismatch("result with nothing expected", '0, rsp);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.status !== want.status || rsp.head_entry !== want.head_entry ||
              rsp.tail_entry !== want.tail_entry || rsp.is_empty !== want.is_empty) begin
            note_mismatch("result mismatch", want, rsp);
          end
        end
      end
      if (req_valid && !req_stall) begin
        moved = 1'b1;
        want = ring_apply(req);
        expected_rsp_q.push_back(want);
        status_seen[want.status]++;
        if (ring_size > peak_size) begin
          peak_size = ring_size;
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $realtime, WATCHDOG_LIMIT, expected_rsp_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic test_empty_ring();
    send_op(ACT_ROTATE, 6'd0);
    send_op(ACT_REMOVE, 6'd5);
    send_op(ACT_UNUSED, 6'd63);
  endtask

  task automatic test_enqueue_and_rotate();
    send_op(ACT_ENQUEUE, 6'd0);
    send_op(ACT_ENQUEUE, 6'd63);
    send_op(ACT_ENQUEUE, 6'd63);
    send_op(ACT_ROTATE, 6'd63);
    send_op(ACT_ROTATE, 6'd21);
    send_op(ACT_UNUSED, 6'd42);
  endtask

  task automatic test_remove_positions();
    send_op(ACT_ENQUEUE, 6'd21);
    send_op(ACT_ENQUEUE, 6'd42);
    send_op(ACT_REMOVE, 6'd21);
    send_op(ACT_REMOVE, 6'd0);
    send_op(ACT_REMOVE, 6'd42);
    send_op(ACT_REMOVE, 6'd42);
    send_op(ACT_ROTATE, 6'd0);
    send_op(ACT_REMOVE, 6'd63);
    send_op(ACT_ENQUEUE, 6'd42);
    send_op(ACT_ROTATE, 6'd42);
    send_op(ACT_REMOVE, 6'd42);
    send_op(ACT_ROTATE, 6'd63);
  endtask

  task automatic run_random_phase(input int count, input bit req_idle, input bit rsp_idle);
    int                  n;
    int                  roll;
    int                  grow_pct;
    logic [ACTION_W-1:0] act;
    logic [ENTRY_W-1:0]  ent;
    req_idle_on = req_idle;
    rsp_idle_on = rsp_idle;
    for (n = 0; n < count; n++) begin
      grow_pct = ((items_sent / MODE_SPAN) % 2 == 0) ? 70 : 25;
      roll = $urandom_range(0, 99);
      ent = ENTRY_W'($urandom);
      if (roll < 4) begin
        act = ACT_UNUSED;
      end else if (roll < 18) begin
        act = ACT_ROTATE;
      end else if ($urandom_range(0, 99) < grow_pct) begin
        act = ACT_ENQUEUE;
        if ($urandom_range(0, 99) < 85) begin
          ent = find_entry(1'b0);
        end
      end else begin
        act = ACT_REMOVE;
        if ($urandom_range(0, 99) < 85) begin
          ent = find_entry(1'b1);
        end
      end
      send_op(act, ent);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(RANDOM_ITEMS / 4, 1'b0, 1'b0);
    run_random_phase(RANDOM_ITEMS / 4, 1'b1, 1'b0);
    run_random_phase(RANDOM_ITEMS / 4, 1'b0, 1'b1);
    run_random_phase(RANDOM_ITEMS - 3 * (RANDOM_ITEMS / 4), 1'b1, 1'b1);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_empty_ring();
    test_enqueue_and_rotate();
    test_remove_positions();
    directed_items = items_sent;
    test_random_traffic();
    req_valid <= 1'b0;
    rsp_idle_on = 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_rsp_q.size() != 0) begin
      error_count++;
      $display("%0d results never arrived", expected_rsp_q.size());
    end
    $display("Sent %0d requests (%0d directed), checked %0d results, peak ring size %0d.",
             items_sent, directed_items, results_checked, peak_size);
    $display("Statuses: done %0d, already %0d, not active %0d, empty %0d; %0d errors.",
             status_seen[ST_DONE], status_seen[ST_ALREADY], status_seen[ST_NOT_ACTIVE],
             status_seen[ST_EMPTY], error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
